@@ hdl/sct_pkg.sv @@
// Package for the sine/cosine series unit: widths, constants, coefficients.
`timescale 1ns / 1ps
package sct_pkg;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;
  localparam int MAG_W = 33;
  localparam int A_W = 33;
  localparam int WIDE_W = MAG_W + 30 - ANGLE_FRAC_BITS;
  localparam int Q_W = 64;
  localparam int N_STEPS = 8;
  localparam int N_MULS = N_STEPS + 1;
  localparam int STEP_W = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [A_W-1:0] PI_Q30 = 33'd3373259426;
  localparam logic [A_W-1:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [A_W-1:0] TAU_Q30 = 33'd6746518852;
  localparam logic [31:0] TAU_Q29 = 32'd3373259426;
  localparam logic [31:0] INV_TAU_Q32 = 32'd683565276;
  localparam logic [Q_W-1:0] ONE_Q60 = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic cosine;
    logic neg;
    logic [A_W-1:0] a;
  } item_t;

  function automatic logic [Q_W-1:0] coef(input logic [3:0] k);
    logic [Q_W-1:0] r;
    case (k)
      4'd0, 4'd1: r = ONE_Q60;
      4'd2: r = ONE_Q60 / 2;
      4'd3: r = ONE_Q60 / 6;
      4'd4: r = ONE_Q60 / 24;
      4'd5: r = ONE_Q60 / 120;
      4'd6: r = ONE_Q60 / 720;
      4'd7: r = ONE_Q60 / 5040;
      4'd8: r = ONE_Q60 / 40320;
      4'd9: r = ONE_Q60 / 362880;
      4'd10: r = ONE_Q60 / 3628800;
      4'd11: r = ONE_Q60 / 39916800;
      4'd12: r = ONE_Q60 / 479001600;
      4'd13: r = ONE_Q60 / 64'd6227020800;
      4'd14: r = ONE_Q60 / 64'd87178291200;
      default: r = ONE_Q60 / 64'd1307674368000;
    endcase
    return r;
  endfunction

  // Sum of the four 32x32 partial products of two magnitudes, >>60 with
  // bits 63,62 cleared, sign applied: a signed Q.60 product
  function automatic logic signed [Q_W-1:0] pp_sum(input logic neg,
                                                   input logic [Q_W-1:0] p00,
                                                   input logic [Q_W-1:0] p01,
                                                   input logic [Q_W-1:0] p10,
                                                   input logic [Q_W-1:0] p11);
    logic [127:0] p;
    logic [Q_W-1:0] r;
    p = {p11, 64'd0} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {64'd0, p00};
    r = {2'b00, p[121:60]};
    return neg ? -$signed(r) : $signed(r);
  endfunction
endpackage

@@ hdl/sine_cosine_taylor_unit.sv @@
// Top level of the sine/cosine series unit.
// Input channel: in_valid/in_ready with command (0 sine, 1 cosine) and a
// signed Q7.24 angle in radians. Output channel: out_valid/out_ready with
// value, signed Q1.30, saturated to +/-1.
// The front end takes the magnitude, reduces angles above 2*pi and folds
// into [0, pi/2] over two stages. A four-entry queue follows, then the
// series pipeline: a squaring step, seven Horner steps and one final step,
// each a 64-bit multiply split over two stages, then the output register.
// Throughput is one transfer per cycle while out_ready stays high; on its
// way to out_valid an item passes the two front registers (the first loads
// on the accepting edge), the queue, the series stages and the output register.
// Reset (rst, synchronous) empties all stages and the queue.
// When the receiver stalls the series pipeline holds; the queue absorbs
// items in flight from the front end, then in_ready drops.
`timescale 1ns / 1ps
module sine_cosine_taylor_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic signed [31:0] angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] value
);
  import sct_pkg::*;
  logic f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  sct_front u_front (.clk, .rst, .in_valid, .in_ready, .command, .angle,
                     .f_valid, .f_ready, .f_item);
  sct_queue u_queue (.clk, .rst, .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
                     .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item));
  sct_series u_series (.clk, .rst, .s_valid(q_valid), .s_ready(q_ready), .s_item(q_item),
                       .out_valid, .out_ready, .value);
endmodule

@@ hdl/sct_front.sv @@
// Front end: magnitude, range reduction and quadrant fold, two stages.
`timescale 1ns / 1ps
module sct_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic signed [31:0] angle,
  output logic f_valid,
  input  logic f_ready,
  output sct_pkg::item_t f_item
);
  import sct_pkg::*;
  logic s1_valid, s1_cos, s1_negin, s1_red;
  logic [MAG_W-1:0] s1_mag;
  logic [ANGLE_FRAC_BITS+31:0] s1_frac;
  logic [MAG_W-1:0] mag;
  logic [A_W-1:0] a_wide, a, a1, a2;
  logic [63:0] p, f2;
  logic [31:0] f32;
  logic n;
  logic adv1, adv2;

  // only used where the magnitude is at most 2*pi, so it fits A_W bits
  function automatic logic [A_W-1:0] s1_mag_shift(input logic [MAG_W-1:0] m);
    return A_W'(m << (30 - ANGLE_FRAC_BITS));
  endfunction

  assign adv2 = !f_valid || f_ready;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;

  always_comb begin
    mag = angle[31] ? (MAG_W'(0) - {angle[31], angle}) : {1'b0, angle};
    p = 64'(mag) * 64'(INV_TAU_Q32);
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv1) s1_valid <= in_valid;
    if (adv1) begin
      s1_cos <= command;
      s1_negin <= angle[31];
      s1_mag <= mag;
      s1_frac <= p[ANGLE_FRAC_BITS+31:0];
      s1_red <= (WIDE_W'(mag) << (30 - ANGLE_FRAC_BITS)) > WIDE_W'(TAU_Q30);
    end
  end

  always_comb begin
    f32 = s1_frac[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
    f2 = 64'(f32) * 64'(TAU_Q29);
    a_wide = s1_mag_shift(s1_mag);
    a = s1_red ? A_W'(f2 >> 31) : a_wide;
    n = !s1_cos && s1_negin;
    a1 = a;
    if (a > PI_Q30) begin
      a1 = TAU_Q30 - a;
      if (!s1_cos) n = !n;
    end
    a2 = a1;
    if (a1 > HALF_PI_Q30) begin
      a2 = PI_Q30 - a1;
      if (s1_cos) n = !n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (adv2) f_valid <= s1_valid;
    if (adv2) f_item <= '{cosine: s1_cos, neg: n, a: a2};
  end
endmodule

@@ hdl/sct_queue.sv @@
// Short FIFO between the front end and the series evaluator.
`timescale 1ns / 1ps
module sct_queue (
  input  logic clk,
  input  logic rst,
  input  logic w_valid,
  output logic w_ready,
  input  sct_pkg::item_t w_item,
  output logic r_valid,
  input  logic r_ready,
  output sct_pkg::item_t r_item
);
  import sct_pkg::*;
  item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0] cnt;
  logic wr, rd;

  assign w_ready = cnt != (QPTR_W+1)'(QDEPTH);
  assign r_valid = cnt != '0;
  assign r_item = mem[rp];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
    if (wr) mem[wp] <= w_item;
  end
endmodule

@@ hdl/sct_series.sv @@
// Back end: Horner series in y = x^2, each multiply split over two stages.
`timescale 1ns / 1ps
module sct_series (
  input  logic clk,
  input  logic rst,
  input  logic s_valid,
  output logic s_ready,
  input  sct_pkg::item_t s_item,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] value
);
  import sct_pkg::*;
  // step 0 squares x; steps 1..7 are Horner steps; step 8 is sine's final x*acc.
  // Stage A of a step registers four 32x32 partial products of the operand
  // magnitudes, stage B sums them and finishes the step.
  logic va [N_MULS];
  logic ca [N_MULS];
  logic nga [N_MULS];
  logic sa [N_MULS];
  logic signed [Q_W-1:0] xa [N_MULS];
  logic signed [Q_W-1:0] ya [N_MULS];
  logic signed [Q_W-1:0] acca [N_MULS];
  logic [Q_W-1:0] pp00 [N_MULS];
  logic [Q_W-1:0] pp01 [N_MULS];
  logic [Q_W-1:0] pp10 [N_MULS];
  logic [Q_W-1:0] pp11 [N_MULS];
  logic vb [N_MULS];
  logic cb [N_MULS];
  logic ngb [N_MULS];
  logic signed [Q_W-1:0] xb [N_MULS];
  logic signed [Q_W-1:0] yb [N_MULS];
  logic signed [Q_W-1:0] accb [N_MULS];
  logic src_v [N_MULS];
  logic src_c [N_MULS];
  logic src_ng [N_MULS];
  logic signed [Q_W-1:0] src_x [N_MULS];
  logic signed [Q_W-1:0] src_y [N_MULS];
  logic signed [Q_W-1:0] src_acc [N_MULS];
  logic signed [Q_W-1:0] opa [N_MULS];
  logic signed [Q_W-1:0] opb [N_MULS];
  logic [Q_W-1:0] ua [N_MULS];
  logic [Q_W-1:0] ub [N_MULS];
  logic signed [Q_W-1:0] prod [N_MULS];
  logic adv;
  logic signed [Q_W-1:0] x_in, res, fin;
  logic [Q_W-1:0] mg;

  assign adv = !out_valid || out_ready;
  assign s_ready = adv;
  assign x_in = $signed({1'b0, s_item.a, 30'd0});

  always_comb begin
    src_v[0] = s_valid;
    src_c[0] = s_item.cosine;
    src_ng[0] = s_item.neg;
    src_x[0] = x_in;
    src_y[0] = '0;
    src_acc[0] = '0;
    opa[0] = x_in;
    opb[0] = x_in;
    for (int j = 1; j < N_MULS; j++) begin
      src_v[j] = vb[j-1];
      src_c[j] = cb[j-1];
      src_ng[j] = ngb[j-1];
      src_x[j] = xb[j-1];
      src_y[j] = yb[j-1];
      src_acc[j] = accb[j-1];
      opa[j] = (j == N_MULS - 1) ? xb[j-1] : yb[j-1];
      opb[j] = accb[j-1];
    end
    for (int j = 0; j < N_MULS; j++) begin
      ua[j] = opa[j][Q_W-1] ? Q_W'(-opa[j]) : Q_W'(opa[j]);
      ub[j] = opb[j][Q_W-1] ? Q_W'(-opb[j]) : Q_W'(opb[j]);
      prod[j] = pp_sum(sa[j], pp00[j], pp01[j], pp10[j], pp11[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < N_MULS; j++) begin
        va[j] <= 1'b0;
        vb[j] <= 1'b0;
      end
    end else if (adv) begin
      for (int j = 0; j < N_MULS; j++) begin
        va[j] <= src_v[j];
        vb[j] <= va[j];
      end
    end
    if (adv) begin
      for (int j = 0; j < N_MULS; j++) begin
        ca[j] <= src_c[j];
        nga[j] <= src_ng[j];
        xa[j] <= src_x[j];
        ya[j] <= src_y[j];
        acca[j] <= src_acc[j];
        sa[j] <= opa[j][Q_W-1] ^ opb[j][Q_W-1];
        pp00[j] <= 64'(ua[j][31:0]) * 64'(ub[j][31:0]);
        pp01[j] <= 64'(ua[j][31:0]) * 64'(ub[j][63:32]);
        pp10[j] <= 64'(ua[j][63:32]) * 64'(ub[j][31:0]);
        pp11[j] <= 64'(ua[j][63:32]) * 64'(ub[j][63:32]);
        cb[j] <= ca[j];
        ngb[j] <= nga[j];
        xb[j] <= xa[j];
      end
      yb[0] <= prod[0];
      accb[0] <= $signed(coef(ca[0] ? 4'd14 : 4'd15));
      for (int j = 1; j < N_MULS - 1; j++) begin
        yb[j] <= ya[j];
        accb[j] <= $signed(coef(ca[j] ? 4'(14 - 2*j) : 4'(15 - 2*j))) - prod[j];
      end
      yb[N_MULS-1] <= ya[N_MULS-1];
      accb[N_MULS-1] <= ca[N_MULS-1] ? acca[N_MULS-1] : prod[N_MULS-1];
    end
  end

  always_comb begin
    res = accb[N_MULS-1];
    mg = res[Q_W-1] ? Q_W'(-res) : Q_W'(res);
    mg = mg >> 30;
    if (mg > Q_W'(64'd1 << 30)) mg = Q_W'(64'd1 << 30);
    fin = (res[Q_W-1] ^ ngb[N_MULS-1]) ? -$signed(mg) : $signed(mg);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vb[N_MULS-1];
    if (adv) value <= fin[VALUE_W-1:0];
  end
endmodule

@@ hdl/sct_checker.sv @@
// Port-level checks for the sine/cosine unit, bound to the top level.
`timescale 1ns / 1ps
module sct_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] value
);
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value <= 32'sd1073741824 && value >= -32'sd1073741824))
    else $error("value out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("stalled result changed");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");
  a_nolatency: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");
endmodule

bind sine_cosine_taylor_unit sct_checker u_checker (.clk, .rst, .in_ready,
  .out_valid, .out_ready, .value);
